// ===== src/triaxial_moving_average_offset_top_assert.svh =====
// Assertion macros for the three-axis moving average block.
`ifndef TRIAXIAL_MOVING_AVERAGE_OFFSET_TOP_ASSERT_SVH
`define TRIAXIAL_MOVING_AVERAGE_OFFSET_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TMAO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TMAO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tmao_pkg.sv =====
// Shared types and constants for the three-axis moving average block.
`default_nettype none
package tmao_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 17;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int IDX_W    = 2;

  // register indexes, byte address is 4 * index
  localparam logic [IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [LEVEL_W-1:0]  level_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } offsets_t;

  // per-cycle control from the top level to each axis
  typedef struct packed {
    logic accept;     // item taken into the input register
    logic advance;    // input register moves to the result register
    logic old_valid;  // slot being overwritten holds a real sample
  } ctrl_t;

endpackage
`default_nettype wire

// ===== src/tmao_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module tmao_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/tmao_cfg.sv =====
// APB register file holding the three calibration offsets.
`default_nettype none
module tmao_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmao_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tmao_pkg::DATA_W-1:0]   pwdata,
  output logic      [tmao_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output tmao_pkg::offsets_t                 offsets
);
  import tmao_pkg::*;

  offsets_t         offsets_r;
  offsets_t         offsets_nxt;
  logic [IDX_W-1:0] idx;
  logic             wr;

  assign pready  = 1'b1;
  assign idx     = paddr[ADDR_W-1:2];
  assign wr      = psel & penable & pwrite & pready;
  assign offsets = offsets_r;

  always_comb begin
    offsets_nxt = offsets_r;
    if (wr) begin
      case (idx)
        REG_OFFSET_X: offsets_nxt.x = pwdata[SAMPLE_W-1:0];
        REG_OFFSET_Y: offsets_nxt.y = pwdata[SAMPLE_W-1:0];
        REG_OFFSET_Z: offsets_nxt.z = pwdata[SAMPLE_W-1:0];
        default:      offsets_nxt = offsets_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offsets_r <= '0;
    end else begin
      offsets_r <= offsets_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_OFFSET_X: prdata = {{(DATA_W-SAMPLE_W){offsets_r.x[SAMPLE_W-1]}}, offsets_r.x};
      REG_OFFSET_Y: prdata = {{(DATA_W-SAMPLE_W){offsets_r.y[SAMPLE_W-1]}}, offsets_r.y};
      REG_OFFSET_Z: prdata = {{(DATA_W-SAMPLE_W){offsets_r.z[SAMPLE_W-1]}}, offsets_r.z};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/tmao_axis.sv =====
// One axis: sample history, running sum, divide by window, offset subtract.
`default_nettype none
module tmao_axis #(
  parameter int WINDOW = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tmao_pkg::ctrl_t             ctrl,
  input  wire logic [$clog2(WINDOW)-1:0]   rd_addr,
  input  wire logic [$clog2(WINDOW)-1:0]   wr_addr,
  input  wire tmao_pkg::sample_t           sample,
  input  wire tmao_pkg::sample_t           offset,
  output tmao_pkg::level_t                 level
);
  import tmao_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_W + SLOT_W;
  // exact reciprocal for dividends below 2**SUM_W
  localparam int SH     = SUM_W + SLOT_W;
  localparam int MUL_W  = SUM_W + 1;
  localparam logic [63:0] ONE = 64'd1;
  localparam logic [63:0] MUL_FULL = ((ONE << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] MUL = MUL_FULL[MUL_W-1:0];

  sample_t             sample_r;
  logic [SAMPLE_W-1:0] old_q;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SUM_W-1:0]    old_ext;
  logic [SUM_W-1:0]    new_ext;
  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic [SUM_W+MUL_W-1:0] prod;
  logic [LEVEL_W-1:0]  quot;
  logic [LEVEL_W-1:0]  avg;
  logic [LEVEL_W-1:0]  off_ext;
  level_t              level_r;

  tmao_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ctrl.advance),
    .wr_addr (wr_addr),
    .wr_data (sample_r),
    .rd_en   (ctrl.accept),
    .rd_addr (rd_addr),
    .rd_data (old_q)
  );

  // before the first wrap the slot counts as zero; the RAM itself is not reset
  assign old_ext = ctrl.old_valid ? {{(SUM_W-SAMPLE_W){old_q[SAMPLE_W-1]}}, old_q} : '0;
  assign new_ext = {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
  assign sum_nxt = sum_r - old_ext + new_ext;

  // truncate toward zero: divide the magnitude, restore the sign
  assign neg     = sum_nxt[SUM_W-1];
  assign mag     = neg ? (~sum_nxt + 1'b1) : sum_nxt;
  assign prod    = (SUM_W+MUL_W)'(mag) * (SUM_W+MUL_W)'(MUL);
  assign quot    = prod[SH +: LEVEL_W];
  assign avg     = neg ? (~quot + 1'b1) : quot;
  assign off_ext = {offset[SAMPLE_W-1], offset};

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      sample_r <= sample;
    end
    if (ctrl.advance) begin
      level_r <= avg - off_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.advance) begin
      sum_r <= sum_nxt;
    end
  end

  assign level = level_r;

endmodule
`default_nettype wire

// ===== src/triaxial_moving_average_offset_top.sv =====
// Flow: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls the output; the
//   history RAM read is issued at accept and the running-sum update, divide
//   and offset run as the item moves from the input to the result register.
// Reset (synchronous, rst_n low): clears slot pointer, fill flag, running sums,
//   offsets and valid flags. The history RAM is not swept: slots not yet
//   written since reset count as zero until the first wrap.
`default_nettype none
module triaxial_moving_average_offset_top #(
  parameter int WINDOW = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire tmao_pkg::sample_t            in_sample_x,
  input  wire tmao_pkg::sample_t            in_sample_y,
  input  wire tmao_pkg::sample_t            in_sample_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output tmao_pkg::level_t                  out_level_x,
  output tmao_pkg::level_t                  out_level_y,
  output tmao_pkg::level_t                  out_level_z,
  output logic                              out_window_filled,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tmao_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tmao_pkg::DATA_W-1:0]  pwdata,
  output logic      [tmao_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import tmao_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  offsets_t          offsets;
  ctrl_t             ctrl;
  logic              accept;
  logic              advance;
  logic              last;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic              filled_r;
  logic              s1_v_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_old_valid_r;
  logic              s1_filled_r;
  logic              out_valid_r;
  logic              out_filled_r;

  assign advance  = s1_v_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_v_r | advance;
  assign accept   = in_valid & in_ready;
  assign last     = (slot_r == LAST_SLOT);
  assign slot_nxt = last ? '0 : slot_r + 1'b1;

  assign ctrl.accept    = accept;
  assign ctrl.advance   = advance;
  assign ctrl.old_valid = s1_old_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      filled_r    <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        slot_r <= slot_nxt;
        if (last) begin
          filled_r <= 1'b1;
        end
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot_r      <= slot_r;
      s1_old_valid_r <= filled_r;
      s1_filled_r    <= filled_r | last;
    end
    if (advance) begin
      out_filled_r <= s1_filled_r;
    end
  end

  tmao_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .offsets (offsets)
  );

  tmao_axis #(.WINDOW (WINDOW)) u_axis_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_addr (slot_r),
    .wr_addr (s1_slot_r),
    .sample  (in_sample_x),
    .offset  (offsets.x),
    .level   (out_level_x)
  );

  tmao_axis #(.WINDOW (WINDOW)) u_axis_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_addr (slot_r),
    .wr_addr (s1_slot_r),
    .sample  (in_sample_y),
    .offset  (offsets.y),
    .level   (out_level_y)
  );

  tmao_axis #(.WINDOW (WINDOW)) u_axis_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_addr (slot_r),
    .wr_addr (s1_slot_r),
    .sample  (in_sample_z),
    .offset  (offsets.z),
    .level   (out_level_z)
  );

  assign out_valid         = out_valid_r;
  assign out_window_filled = out_filled_r;

`include "triaxial_moving_average_offset_top_assert.svh"

  `TMAO_ASSERT_NEXT(a_wrap, accept && last, filled_r && (slot_r == '0), "slot wrap lost")
  `TMAO_ASSERT_NEXT(a_filled_sticky, filled_r, filled_r, "fill flag dropped")
  `TMAO_ASSERT_NEXT(a_stage_hold, s1_v_r && !advance, s1_v_r, "stalled item lost")
  `TMAO_ASSERT_NOW(a_slot_range, s1_v_r, s1_slot_r <= LAST_SLOT, "slot out of window")

endmodule
`default_nettype wire
